@@ hdl/q16d_pkg.sv @@
// Shared types, constants and helpers for the Q15.16 to decimal text converter.
// No dependencies; used by q16d_conv and q15_16_to_decimal_ascii_top.
package q16d_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int NUM_W     = 17;   // holds integer part (<= 32768) and fraction (<= 99998)
    localparam int FRAC_DIGS = 5;
    localparam int INT_DIGS  = 5;

    localparam logic [16:0] FRAC_SCALE = 17'd100000;
    localparam logic [15:0] ROUND_HALF = 16'd32768;

    // Character slots of the fixed text layout: sign, five integer digits,
    // point, five fraction digits.
    localparam logic [3:0] POS_SIGN  = 4'd0;
    localparam logic [3:0] POS_POINT = 4'd6;
    localparam logic [3:0] POS_LAST  = 4'd11;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [3:0]        CH_DIGIT_HI = 4'h3;

    // floor(x / 10^(k+1)) = (x * RECIP[k]) >> SHIFT[k], exact for x < 2^17
    localparam logic [17:0] RECIP [4] = '{18'd209716, 18'd167773, 18'd134218, 18'd214749};
    localparam int          SHIFT [4] = '{21, 24, 27, 31};

    typedef struct packed {
        logic                              neg;
        logic [2:0]                        ndig;   // integer digits to print, 1..5
        logic [INT_DIGS-1:0][DIGIT_W-1:0]  idig;   // index 0 = ones
        logic [FRAC_DIGS-1:0][DIGIT_W-1:0] fdig;   // index 0 = tenths
    } t_text;

    function automatic logic [NUM_W-1:0] div_pow10(input logic [NUM_W-1:0] x,
                                                   input logic [1:0] k);
        logic [34:0] prod;
        prod = 35'(x) * 35'(RECIP[k]);
        return NUM_W'(prod >> SHIFT[k]);
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [NUM_W-1:0] q_lo,
                                                    input logic [NUM_W-1:0] q_hi);
        logic [NUM_W-1:0] rem;
        rem = q_lo - NUM_W'(q_hi * NUM_W'(10));
        return rem[DIGIT_W-1:0];
    endfunction

endpackage

@@ hdl/q16d_conv.sv @@
// Four-stage pipeline: Q15.16 word in, decimal digits of integer and fraction out.
// Depends on q16d_pkg.
module q16d_conv
    import q16d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_vld,
    input  logic               i_rdy,
    output t_text              o_txt
);

    // stage 1: input register
    logic               r1_vld;
    logic [VALUE_W-1:0] r1_value;
    // stage 2: sign, integer part, scaled fraction
    logic               r2_vld, r2_neg;
    logic [NUM_W-1:0]   r2_ix, r2_fx;
    // stage 3: quotients by 10, 100, 1000, 10000
    logic               r3_vld, r3_neg;
    logic [NUM_W-1:0]   r3_ix, r3_fx;
    logic [3:0][NUM_W-1:0] r3_iq, r3_fq;
    // stage 4: digits
    logic               r4_vld;
    t_text              r4_txt;

    logic rdy1, rdy2, rdy3, rdy4;
    logic [VALUE_W-1:0] mag;
    logic [32:0]        fprod;
    t_text              n_txt;

    assign rdy4  = !r4_vld || i_rdy;
    assign rdy3  = !r3_vld || rdy4;
    assign rdy2  = !r2_vld || rdy3;
    assign rdy1  = !r1_vld || rdy2;
    assign o_rdy = rdy1;
    assign o_vld = r4_vld;
    assign o_txt = r4_txt;

    // most negative word negates to itself, read unsigned as 2^31
    assign mag   = r1_value[VALUE_W-1] ? (VALUE_W'(0) - r1_value) : r1_value;
    assign fprod = 33'(mag[15:0]) * 33'(FRAC_SCALE) + 33'(ROUND_HALF);

    always_comb begin
        n_txt.neg = r3_neg;
        n_txt.idig[0] = digit_of(r3_ix, r3_iq[0]);
        n_txt.fdig[4] = digit_of(r3_fx, r3_fq[0]);
        for (int k = 1; k < 4; k++) begin
            n_txt.idig[k]   = digit_of(r3_iq[k-1], r3_iq[k]);
            n_txt.fdig[4-k] = digit_of(r3_fq[k-1], r3_fq[k]);
        end
        n_txt.idig[4] = r3_iq[3][DIGIT_W-1:0];
        n_txt.fdig[0] = r3_fq[3][DIGIT_W-1:0];
        priority if (r3_iq[3] != '0) n_txt.ndig = 3'd5;
        else if (r3_iq[2] != '0)     n_txt.ndig = 3'd4;
        else if (r3_iq[1] != '0)     n_txt.ndig = 3'd3;
        else if (r3_iq[0] != '0)     n_txt.ndig = 3'd2;
        else                         n_txt.ndig = 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (rdy1) r1_vld <= i_vld;
            if (rdy2) r2_vld <= r1_vld;
            if (rdy3) r3_vld <= r2_vld;
            if (rdy4) r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r1_value <= i_value;
        if (rdy2) begin
            r2_neg <= r1_value[VALUE_W-1];
            r2_ix  <= NUM_W'(mag[31:16]);
            r2_fx  <= fprod[32:16];
        end
        if (rdy3) begin
            r3_neg <= r2_neg;
            r3_ix  <= r2_ix;
            r3_fx  <= r2_fx;
            for (int k = 0; k < 4; k++) begin
                r3_iq[k] <= div_pow10(r2_ix, 2'(k));
                r3_fq[k] <= div_pow10(r2_fx, 2'(k));
            end
        end
        if (rdy4) r4_txt <= n_txt;
    end

endmodule

@@ hdl/q15_16_to_decimal_ascii_top.sv @@
// Q15.16 to decimal ASCII text: conversion pipeline plus character serializer.
// Depends on q16d_pkg and q16d_conv.
//
//  channel   dir  payload                         words per value
//  s_axis    in   tdata[31:0] value (Q15.16)      1
//  m_axis    out  tdata[7:0] character, tlast     7 to 12
//
// One character leaves per cycle while m_axis_tready is high; a value gives 7 to 12
// characters (optional sign, 1-5 integer digits, point, five fraction digits).
// The conversion pipeline is four registers deep and fills while the previous
// text drains, so texts follow each other without gaps.
// Reset (i_rst_n low at a clock edge) clears only the valid flags.
// m_axis_tready low holds the current character; up to four values wait behind it.
module q15_16_to_decimal_ascii_top
    import q16d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [CHAR_W-1:0]  m_axis_tdata,   // [7:0] character
    output logic               m_axis_tlast
);

    logic       conv_vld, txt_load;
    t_text      conv_txt;
    t_text      r_txt;
    logic       r_txt_vld;
    logic [3:0] r_pos, n_pos;
    logic [3:0] int_start, load_start;
    logic [3:0] iidx, fidx;

    q16d_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_value (s_axis_tdata),
        .o_vld   (conv_vld),
        .i_rdy   (txt_load),
        .o_txt   (conv_txt)
    );

    assign txt_load   = !r_txt_vld || (m_axis_tready && (r_pos == POS_LAST));
    assign int_start  = POS_POINT - 4'(r_txt.ndig);
    assign load_start = conv_txt.neg ? POS_SIGN : (POS_POINT - 4'(conv_txt.ndig));
    // after the sign, jump over unused leading integer slots
    assign n_pos      = (r_pos == POS_SIGN) ? int_start : (r_pos + 4'd1);

    assign iidx = POS_POINT - 4'd1 - r_pos;
    assign fidx = r_pos - POS_POINT - 4'd1;

    always_comb begin
        priority if (r_pos == POS_SIGN)
            m_axis_tdata = CH_MINUS;
        else if (r_pos < POS_POINT)
            m_axis_tdata = {CH_DIGIT_HI, r_txt.idig[iidx[2:0]]};
        else if (r_pos == POS_POINT)
            m_axis_tdata = CH_POINT;
        else
            m_axis_tdata = {CH_DIGIT_HI, r_txt.fdig[fidx[2:0]]};
    end

    assign m_axis_tvalid = r_txt_vld;
    assign m_axis_tlast  = (r_pos == POS_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_txt_vld <= 1'b0;
        end else if (txt_load) begin
            r_txt_vld <= conv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (txt_load) begin
            r_txt <= conv_txt;
            r_pos <= load_start;
        end else if (m_axis_tready) begin
            r_pos <= n_pos;
        end
    end

endmodule
